// File: rtl/core/lema_pkg.sv
// Shared types and constants for the dual-channel light EMA filter.
// Holds payload structs, op and register codes, controller/datapath command types.
// No dependencies; compile first.
package lema_pkg;

  // Default values handed to the top-level parameters
  localparam int RawBitsDefault       = 20;
  localparam int ValueFracBitsDefault = 12;

  // Fixed field widths of the channel payloads and configuration registers
  localparam int RawCountW = 20;
  localparam int ValueW    = 32;
  localparam int CountW    = 32;
  localparam int ScaleW    = 32;
  localparam int AlphaW    = 16;
  localparam int SettleW   = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  // Register reset values
  localparam logic [ScaleW-1:0]  UvScaleReset      = 32'd29178;
  localparam logic [ScaleW-1:0]  AlsScaleReset     = 32'd3355443;
  localparam logic [AlphaW-1:0]  EmaAlphaReset     = 16'd19661;
  localparam logic [SettleW-1:0] SettleSamplesReset = 4'd2;
  localparam logic               DefaultModeReset  = 1'b0;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_CLEAR    = 2'd2
  } op_code_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UV_SCALE       = 3'd0,
    REG_ALS_SCALE      = 3'd1,
    REG_EMA_ALPHA      = 3'd2,
    REG_SETTLE_SAMPLES = 3'd3,
    REG_DEFAULT_MODE   = 3'd4
  } cfg_reg_t;

  // What a transaction does to the state at commit
  typedef enum logic [2:0] {
    KIND_FILTER   = 3'd0,
    KIND_DISCARD  = 3'd1,
    KIND_SET_MODE = 3'd2,
    KIND_CLEAR    = 3'd3,
    KIND_STATUS   = 3'd4
  } item_kind_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [RawCountW-1:0] raw_count;
    logic                 reading_ok;
    logic                 new_mode;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              held;
    logic              settling;
    logic              current_mode;
    logic [CountW-1:0] uv_invalid_total;
    logic [CountW-1:0] als_invalid_total;
    logic [CountW-1:0] uv_sample_total;
    logic [CountW-1:0] als_sample_total;
    logic [CountW-1:0] mode_changes;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_alpha;
    logic       diff_en;
    logic       commit;
    item_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    item_kind_t in_kind;
  } dp_status_t;

endpackage

// File: rtl/core/lema_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// Payload type is set per instance; no package dependency.
interface lema_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/dual_channel_light_ema_filter_unit.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    op, raw_count, reading_ok, new_mode
// out_ch    out  valid/ready    value, held, settling, current_mode, five counters
// cfg       in   cfg_we only    cfg_index selects register, cfg_data
//
// A filtered sample steps through the scale multiply, difference, alpha multiply
// and commit states, the two multiplies sharing one 32 x max(RAW_BITS, 16)
// multiplier; its result is registered at commit, after which the controller
// returns to idle. Discarded samples, set-mode, clear and status transactions go
// straight from acceptance to commit.
// Synchronous active-high reset restores register defaults and clears filter state.
// A stalled result holds in the output register; the next transaction is taken
// meanwhile and waits at commit until the output register frees.
module dual_channel_light_ema_filter_unit #(
  parameter int RAW_BITS        = lema_pkg::RawBitsDefault,
  parameter int VALUE_FRAC_BITS = lema_pkg::ValueFracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lema_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lema_pkg::CfgDataW-1:0] cfg_data,
  lema_stream_if.sink                   in_ch,
  lema_stream_if.source                 out_ch
);
  import lema_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   in_item;
  out_item_t  out_item;

  assign in_item     = in_ch.data;
  assign out_ch.data = out_item;

  lema_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lema_dp #(
    .RAW_BITS        (RAW_BITS),
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // commit never overwrites a result that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("commit while output register occupied");

  // one transaction at a time: busy right after acceptance
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while busy");

  // a freshly filtered value never comes out while settling
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.data.held) |-> !out_ch.data.settling)
    else $error("new value reported during settling");

  // a commit always follows its transaction and is followed by a valid result
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_ch.valid)
    else $error("result not presented after commit");
`endif

endmodule

// File: rtl/core/lema_ctrl.sv
// Sequencing state machine for the light EMA filter.
// Depends on lema_pkg for command and status types.
module lema_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lema_pkg::dp_status_t status,
  output lema_pkg::dp_cmd_t    cmd
);
  import lema_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCALE = 5'b00010,
    S_DIFF  = 5'b00100,
    S_ALPHA = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t     state, state_next;
  item_kind_t kind, kind_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    cmd           = '0;
    cmd.kind      = kind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          kind_next = status.in_kind;
          state_next = (status.in_kind == KIND_FILTER) ? S_SCALE : S_WRITE;
        end
      end
      S_SCALE: begin
        cmd.mul_en = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_ALPHA;
      end
      S_ALPHA: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_alpha = 1'b1;
        state_next    = S_WRITE;
      end
      S_WRITE: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= KIND_STATUS;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      kind      <= kind_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/core/lema_dp.sv
// Datapath of the light EMA filter: registers, shared multiplier, EMA update.
// Depends on lema_pkg for payload, register codes and command types.
module lema_dp #(
  parameter int RAW_BITS        = lema_pkg::RawBitsDefault,
  parameter int VALUE_FRAC_BITS = lema_pkg::ValueFracBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lema_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [lema_pkg::CfgDataW-1:0]       cfg_data,
  input  lema_pkg::in_item_t                  in_item,
  input  lema_pkg::dp_cmd_t                   cmd,
  output lema_pkg::dp_status_t                status,
  output lema_pkg::out_item_t                 out_item
);
  import lema_pkg::*;

  localparam int MulBW      = (RAW_BITS > AlphaW) ? RAW_BITS : AlphaW;
  localparam int ProdW      = ScaleW + MulBW;
  localparam int ScaleShift = 24 - VALUE_FRAC_BITS;

  // configuration registers
  logic [ScaleW-1:0]  uv_scale, als_scale;
  logic [AlphaW-1:0]  ema_alpha;
  logic [SettleW-1:0] settle_samples;
  logic               default_mode;

  // filter state
  logic               mode_reg, mode_reg_next;
  logic               settling_flag, settling_flag_next;
  logic [SettleW-1:0] settle_left, settle_left_next;
  logic [ValueW-1:0]  uv_filtered, uv_filtered_next;
  logic [ValueW-1:0]  als_filtered, als_filtered_next;
  logic               uv_seeded, uv_seeded_next;
  logic               als_seeded, als_seeded_next;
  logic [CountW-1:0]  uv_bad_count, uv_bad_count_next;
  logic [CountW-1:0]  als_bad_count, als_bad_count_next;
  logic [CountW-1:0]  uv_good_count, uv_good_count_next;
  logic [CountW-1:0]  als_good_count, als_good_count_next;
  logic [CountW-1:0]  switch_total, switch_total_next;

  // working registers
  logic [RAW_BITS-1:0] raw_q;
  logic                new_mode_q;
  logic [ProdW-1:0]    prod;
  logic [ValueW-1:0]   x_q;
  logic [ValueW-1:0]   diff_q;
  logic                ge_q;

  logic [ScaleW-1:0]  mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   shifted;
  logic [ValueW-1:0]  x_sat;
  logic [ValueW-1:0]  y_cur;
  logic               seeded_cur;
  logic [ValueW-1:0]  corr;
  logic [ValueW-1:0]  ema_new;
  logic [SettleW-1:0] left_dec;
  out_item_t          out_next;

  // classify the incoming transaction against the current settling state
  always_comb begin
    case (in_item.op)
      OP_SAMPLE:   status.in_kind = (settling_flag || !in_item.reading_ok) ?
                                    KIND_DISCARD : KIND_FILTER;
      OP_SET_MODE: status.in_kind = KIND_SET_MODE;
      OP_CLEAR:    status.in_kind = KIND_CLEAR;
      default:     status.in_kind = KIND_STATUS;
    endcase
  end

  // shared multiplier operands: count times scale, then alpha times difference
  assign mul_a = cmd.mul_alpha ? diff_q : (mode_reg ? uv_scale : als_scale);
  assign mul_b = cmd.mul_alpha ? MulBW'(ema_alpha) : MulBW'(raw_q);

  assign shifted    = prod >> ScaleShift;
  assign x_sat      = (|shifted[ProdW-1:ValueW]) ? '1 : shifted[ValueW-1:0];
  assign y_cur      = mode_reg ? uv_filtered : als_filtered;
  assign seeded_cur = mode_reg ? uv_seeded : als_seeded;
  assign corr       = prod[AlphaW +: ValueW];
  assign left_dec   = (settle_left != '0) ? settle_left - 1'b1 : settle_left;

  always_comb begin
    if (!seeded_cur) begin
      ema_new = x_q;
    end else if (ge_q) begin
      ema_new = y_cur + corr;
    end else begin
      ema_new = y_cur - corr;
    end
  end

  always_comb begin
    mode_reg_next       = mode_reg;
    settling_flag_next  = settling_flag;
    settle_left_next    = settle_left;
    uv_filtered_next    = uv_filtered;
    als_filtered_next   = als_filtered;
    uv_seeded_next      = uv_seeded;
    als_seeded_next     = als_seeded;
    uv_bad_count_next   = uv_bad_count;
    als_bad_count_next  = als_bad_count;
    uv_good_count_next  = uv_good_count;
    als_good_count_next = als_good_count;
    switch_total_next   = switch_total;
    case (cmd.kind)
      KIND_FILTER: begin
        if (mode_reg) begin
          uv_filtered_next   = ema_new;
          uv_seeded_next     = 1'b1;
          uv_good_count_next = uv_good_count + 1'b1;
        end else begin
          als_filtered_next   = ema_new;
          als_seeded_next     = 1'b1;
          als_good_count_next = als_good_count + 1'b1;
        end
      end
      KIND_DISCARD: begin
        if (settling_flag) begin
          settle_left_next = left_dec;
          if (left_dec == '0) begin
            settling_flag_next = 1'b0;
          end
        end
        if (mode_reg) begin
          uv_bad_count_next = uv_bad_count + 1'b1;
        end else begin
          als_bad_count_next = als_bad_count + 1'b1;
        end
      end
      KIND_SET_MODE: begin
        if (mode_reg != new_mode_q) begin
          switch_total_next = switch_total + 1'b1;
        end
        mode_reg_next      = new_mode_q;
        settling_flag_next = 1'b1;
        settle_left_next   = settle_samples;
      end
      KIND_CLEAR: begin
        mode_reg_next       = default_mode;
        settling_flag_next  = 1'b0;
        settle_left_next    = '0;
        uv_filtered_next    = '0;
        als_filtered_next   = '0;
        uv_seeded_next      = 1'b0;
        als_seeded_next     = 1'b0;
        uv_bad_count_next   = '0;
        als_bad_count_next  = '0;
        uv_good_count_next  = '0;
        als_good_count_next = '0;
        switch_total_next   = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_next.value             = mode_reg_next ? uv_filtered_next : als_filtered_next;
    out_next.held              = (cmd.kind != KIND_FILTER);
    out_next.settling          = settling_flag_next;
    out_next.current_mode      = mode_reg_next;
    out_next.uv_invalid_total  = uv_bad_count_next;
    out_next.als_invalid_total = als_bad_count_next;
    out_next.uv_sample_total   = uv_good_count_next;
    out_next.als_sample_total  = als_good_count_next;
    out_next.mode_changes      = switch_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_scale       <= UvScaleReset;
      als_scale      <= AlsScaleReset;
      ema_alpha      <= EmaAlphaReset;
      settle_samples <= SettleSamplesReset;
      default_mode   <= DefaultModeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UV_SCALE:       uv_scale       <= cfg_data[ScaleW-1:0];
        REG_ALS_SCALE:      als_scale      <= cfg_data[ScaleW-1:0];
        REG_EMA_ALPHA:      ema_alpha      <= cfg_data[AlphaW-1:0];
        REG_SETTLE_SAMPLES: settle_samples <= cfg_data[SettleW-1:0];
        REG_DEFAULT_MODE:   default_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= DefaultModeReset;
      settling_flag  <= 1'b0;
      settle_left    <= '0;
      uv_filtered    <= '0;
      als_filtered   <= '0;
      uv_seeded      <= 1'b0;
      als_seeded     <= 1'b0;
      uv_bad_count   <= '0;
      als_bad_count  <= '0;
      uv_good_count  <= '0;
      als_good_count <= '0;
      switch_total   <= '0;
    end else if (cmd.commit) begin
      mode_reg       <= mode_reg_next;
      settling_flag  <= settling_flag_next;
      settle_left    <= settle_left_next;
      uv_filtered    <= uv_filtered_next;
      als_filtered   <= als_filtered_next;
      uv_seeded      <= uv_seeded_next;
      als_seeded     <= als_seeded_next;
      uv_bad_count   <= uv_bad_count_next;
      als_bad_count  <= als_bad_count_next;
      uv_good_count  <= uv_good_count_next;
      als_good_count <= als_good_count_next;
      switch_total   <= switch_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_q      <= RAW_BITS'(in_item.raw_count);
      new_mode_q <= in_item.new_mode;
    end
    if (cmd.mul_en) begin
      prod <= {{MulBW{1'b0}}, mul_a} * {{ScaleW{1'b0}}, mul_b};
    end
    if (cmd.diff_en) begin
      x_q    <= x_sat;
      ge_q   <= (x_sat >= y_cur);
      diff_q <= (x_sat >= y_cur) ? x_sat - y_cur : y_cur - x_sat;
    end
    if (cmd.commit) begin
      out_item <= out_next;
    end
  end

endmodule

// File: dv/tb_dual_channel_light_ema_filter_unit.sv
// Self-checking testbench for dual_channel_light_ema_filter_unit: directed table, then
// random phases under several register settings, each result checked against a predictor or table.
// Depends on lema_pkg and lema_stream_if from the RTL.
module tb_dual_channel_light_ema_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lema_pkg::*;

  localparam logic [1:0] OP_STATUS   = 2'd3;  // unused code, reports status only
  localparam int         FracShift   = 24 - ValueFracBitsDefault;
  localparam int         RandPerPhase = 120;
  localparam int         NumPhases    = 7;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  lema_stream_if #(.payload_t(in_item_t))  in_if ();
  lema_stream_if #(.payload_t(out_item_t)) out_if ();

  dual_channel_light_ema_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Register shadows
  logic [31:0] sh_uv_scale, sh_als_scale;
  logic [15:0] sh_alpha;
  logic [3:0]  sh_settle;
  logic        sh_default_mode;

  // Filter state
  logic        chan_mode, settle_on;
  logic [3:0]  settle_cnt;
  logic [31:0] uv_ema, als_ema;
  logic        uv_primed, als_primed;
  logic [31:0] uv_drop, als_drop, uv_kept, als_kept, mode_flips;

  out_item_t pending_status[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count = 0;
  bit        tx_burst = 0;
  bit        rx_burst = 0;

  function automatic void clear_filter_state();
    chan_mode  = sh_default_mode;
    settle_on  = 1'b0;
    settle_cnt = '0;
    uv_ema     = '0;
    als_ema    = '0;
    uv_primed  = 1'b0;
    als_primed = 1'b0;
    uv_drop    = '0;
    als_drop   = '0;
    uv_kept    = '0;
    als_kept   = '0;
    mode_flips = '0;
  endfunction

  function automatic logic [31:0] scale_count(logic [RawCountW-1:0] raw, logic [31:0] scale);
    logic [63:0] prod;
    prod = ({44'd0, raw} * {32'd0, scale}) >> FracShift;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  // Move y toward x by alpha of the gap, truncating the step
  function automatic logic [31:0] ema_fold(logic [31:0] y, logic primed, logic [31:0] x);
    logic [63:0] step;
    if (!primed) return x;
    if (x >= y) begin
      step = ({48'd0, sh_alpha} * {32'd0, x - y}) >> 16;
      return y + step[31:0];
    end
    step = ({48'd0, sh_alpha} * {32'd0, y - x}) >> 16;
    return y - step[31:0];
  endfunction

  function automatic out_item_t next_status(in_item_t it);
    out_item_t r;
    logic      held;
    logic      discard;
    held = 1'b1;
    case (it.op)
      OP_SAMPLE: begin
        discard = settle_on || !it.reading_ok;
        if (settle_on) begin
          if (settle_cnt != 0) settle_cnt = settle_cnt - 4'd1;
          if (settle_cnt == 0) settle_on = 1'b0;
        end
        if (discard) begin
          if (chan_mode) uv_drop = uv_drop + 1;
          else als_drop = als_drop + 1;
        end else if (chan_mode) begin
          uv_ema    = ema_fold(uv_ema, uv_primed, scale_count(it.raw_count, sh_uv_scale));
          uv_primed = 1'b1;
          uv_kept   = uv_kept + 1;
          held      = 1'b0;
        end else begin
          als_ema    = ema_fold(als_ema, als_primed, scale_count(it.raw_count, sh_als_scale));
          als_primed = 1'b1;
          als_kept   = als_kept + 1;
          held       = 1'b0;
        end
      end
      OP_SET_MODE: begin
        if (chan_mode != it.new_mode) mode_flips = mode_flips + 1;
        chan_mode  = it.new_mode;
        settle_on  = 1'b1;
        settle_cnt = sh_settle;
      end
      OP_CLEAR: clear_filter_state();
      default: ;
    endcase
    r.value             = chan_mode ? uv_ema : als_ema;
    r.held              = held;
    r.settling          = settle_on;
    r.current_mode      = chan_mode;
    r.uv_invalid_total  = uv_drop;
    r.als_invalid_total = als_drop;
    r.uv_sample_total   = uv_kept;
    r.als_sample_total  = als_kept;
    r.mode_changes      = mode_flips;
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 75)      it.op = OP_SAMPLE;
    else if (pick < 89) it.op = OP_SET_MODE;
    else if (pick < 93) it.op = OP_CLEAR;
    else                it.op = OP_STATUS;
    case ($urandom_range(0, 7))
      0:       it.raw_count = '0;
      1:       it.raw_count = '1;
      2:       it.raw_count = RawCountW'($urandom_range(0, 255));
      default: it.raw_count = RawCountW'($urandom());
    endcase
    it.reading_ok = ($urandom_range(0, 9) != 0);
    it.new_mode   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [RawCountW-1:0] raw, logic ok,
                                  logic nm, bit typed, out_item_t want);
    dir_row_t row;
    row.item.op         = op;
    row.item.raw_count  = raw;
    row.item.reading_ok = ok;
    row.item.new_mode   = nm;
    row.typed           = typed;
    row.want            = want;
    dir_rows.push_back(row);
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(in_item_t it, out_item_t want, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_status.push_back(want);
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_UV_SCALE:       sh_uv_scale     = data;
      REG_ALS_SCALE:      sh_als_scale    = data;
      REG_EMA_ALPHA:      sh_alpha        = data[15:0];
      REG_SETTLE_SAMPLES: sh_settle       = data[3:0];
      REG_DEFAULT_MODE:   sh_default_mode = data[0];
      default: ;
    endcase
  endtask

  // Result side: random stalls, check each transaction against the oldest expectation
  initial begin : result_sink
    out_item_t   got, want;
    logic [31:0] g[9], w[9];
    string       names[9];
    int          stall;
    int          n;
    names = '{"value", "held", "settling", "current_mode", "uv_invalid_total",
              "als_invalid_total", "uv_sample_total", "als_sample_total", "mode_changes"};
    n = 0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait(rx_burst);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got = out_if.data;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n));
      end else begin
        want = pending_status.pop_front();
        g = '{got.value, {31'd0, got.held}, {31'd0, got.settling}, {31'd0, got.current_mode},
              got.uv_invalid_total, got.als_invalid_total, got.uv_sample_total,
              got.als_sample_total, got.mode_changes};
        w = '{want.value, {31'd0, want.held}, {31'd0, want.settling},
              {31'd0, want.current_mode}, want.uv_invalid_total, want.als_invalid_total,
              want.uv_sample_total, want.als_sample_total, want.mode_changes};
        for (int f = 0; f < 9; f++) begin
          if (g[f] !== w[f])
            report_mismatch($sformatf("result %0d %s: got %h want %h", n, names[f], g[f], w[f]));
        end
      end
      n++;
    end
  end

  initial begin : stimulus
    out_item_t   t;
    out_item_t   want;
    in_item_t    it;
    logic [31:0] cfg[5];

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;

    sh_uv_scale     = UvScaleReset;
    sh_als_scale    = AlsScaleReset;
    sh_alpha        = EmaAlphaReset;
    sh_settle       = SettleSamplesReset;
    sh_default_mode = DefaultModeReset;
    clear_filter_state();

    // Directed table, run under the reset register values
    t = '0;
    t.held = 1'b1;
    add_row(OP_STATUS, '0, 1'b0, 1'b0, 1, t);        // status straight after reset
    t.als_invalid_total = 1;
    add_row(OP_SAMPLE, '1, 1'b0, 1'b1, 1, t);        // bad read is discarded
    t.held = 1'b0;
    t.als_sample_total = 1;
    add_row(OP_SAMPLE, '0, 1'b1, 1'b0, 1, t);        // first good sample seeds the EMA
    add_row(OP_SAMPLE, '1, 1'b1, 1'b0, 0, t);
    add_row(OP_SET_MODE, '0, 1'b1, 1'b0, 0, t);      // same mode: no change counted
    add_row(OP_SAMPLE, '1, 1'b1, 1'b0, 0, t);        // discarded while settling
    add_row(OP_SAMPLE, '1, 1'b1, 1'b1, 0, t);        // last settling sample
    add_row(OP_SAMPLE, 20'd12345, 1'b1, 1'b0, 0, t);
    add_row(OP_SET_MODE, 20'd7, 1'b0, 1'b1, 0, t);   // real switch to UV
    add_row(OP_SAMPLE, '1, 1'b1, 1'b0, 0, t);
    add_row(OP_SAMPLE, '0, 1'b0, 1'b1, 0, t);
    add_row(OP_SAMPLE, '1, 1'b1, 1'b0, 0, t);        // seeds the UV channel
    add_row(OP_SAMPLE, '1, 1'b0, 1'b0, 0, t);
    add_row(OP_SAMPLE, 20'd1, 1'b1, 1'b1, 0, t);     // EMA moves down toward x
    add_row(OP_STATUS, '1, 1'b1, 1'b1, 0, t);
    add_row(OP_SET_MODE, '1, 1'b1, 1'b1, 0, t);
    t = '0;
    t.held = 1'b1;
    add_row(OP_CLEAR, '1, 1'b1, 1'b1, 1, t);
    add_row(OP_SAMPLE, '1, 1'b1, 1'b0, 0, t);
    add_row(OP_SET_MODE, 20'hAAAAA, 1'b0, 1'b1, 0, t);
    add_row(OP_STATUS, 20'h55555, 1'b0, 1'b0, 0, t);
    add_row(OP_CLEAR, 20'd0, 1'b0, 1'b0, 1, t);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      want = next_status(dir_rows[i].item);
      if (dir_rows[i].typed) want = dir_rows[i].want;
      send_item(dir_rows[i].item, want, draw_wait(1'b0));
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p)
        0:       cfg = '{32'hFFFF_FFFF, 32'h0, 32'h0000_FFFF, 32'd15, 32'd1};
        1:       cfg = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'd0, 32'd0};
        3:       cfg = '{32'h0100_0000, $urandom(), 32'h0000_8000, 32'd1, 32'd1};
        5:       cfg = '{UvScaleReset, AlsScaleReset, 32'(EmaAlphaReset),
                         32'(SettleSamplesReset), 32'(DefaultModeReset)};
        default: cfg = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      endcase
      for (int k = 0; k < 5; k++) write_reg(cfg_reg_t'(k), cfg[k]);
      cfg_we <= 1'b0;

      for (int k = 0; k < RandPerPhase; k++) begin
        if (k % 30 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        // Start each phase with a clear so the new default mode takes effect
        if (k == 0) begin
          it = rand_item();
          it.op = OP_CLEAR;
        end else begin
          it = rand_item();
        end
        want = next_status(it);
        send_item(it, want, draw_wait(tx_burst));
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    rx_burst = 1'b0;
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
